### rtl/miller_rabin_primality_test_unit_assert.svh
// Assertion macros shared by the primality test unit.
`ifndef MILLER_RABIN_PRIMALITY_TEST_UNIT_ASSERT_SVH
`define MILLER_RABIN_PRIMALITY_TEST_UNIT_ASSERT_SVH

// Same-cycle implication on clk_i, quiet during reset.
`define MRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, quiet during reset.
`define MRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mrp_pkg.sv
// Types, constants and the base table of the primality test unit.
package mrp_pkg;

  localparam int unsigned NumBases = 13;
  localparam int unsigned BaseW    = 6;
  localparam int unsigned BaseIdxW = 4;

  // Request to the shared modular multiplier.
  typedef struct packed {
    logic start;
    logic square;
  } mul_req_t;

  function automatic logic [BaseW-1:0] base_value(input logic [BaseIdxW-1:0] idx);
    logic [BaseW-1:0] v;
    case (idx)
      4'd0:    v = 6'd2;
      4'd1:    v = 6'd3;
      4'd2:    v = 6'd5;
      4'd3:    v = 6'd7;
      4'd4:    v = 6'd11;
      4'd5:    v = 6'd13;
      4'd6:    v = 6'd17;
      4'd7:    v = 6'd19;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd29;
      4'd10:   v = 6'd31;
      4'd11:   v = 6'd37;
      4'd12:   v = 6'd41;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/mrp_mulmod.sv
// Radix-2 shift-and-add modular multiplier, one modular addition per cycle.
module mrp_mulmod #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrp_pkg::mul_req_t   req_i,
  input  logic [WIDTH-1:0]    a_i,
  input  logic [WIDTH-1:0]    b_i,
  input  logic [WIDTH-1:0]    n_i,
  output logic [WIDTH-1:0]    result_o,
  output logic                done_o
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] a_q, b_q, n_q, r_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q, add_phase_q, done_q;

  logic [WIDTH-1:0] y;
  logic [WIDTH:0]   sum;
  logic [WIDTH+1:0] diff;
  logic [WIDTH-1:0] r_d;

  // Double in the first phase, add the multiplicand in the second.
  assign y    = add_phase_q ? a_q : r_q;
  assign sum  = {1'b0, r_q} + {1'b0, y};
  assign diff = {1'b0, sum} - {2'b00, n_q};
  assign r_d  = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      add_phase_q <= 1'b0;
      done_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q         <= req_i.square ? b_i : a_i;
        b_q         <= b_i;
        n_q         <= n_i;
        r_q         <= '0;
        cnt_q       <= CntW'(WIDTH - 1);
        add_phase_q <= 1'b0;
        run_q       <= 1'b1;
      end else if (run_q) begin
        r_q <= r_d;
        if (!add_phase_q && b_q[WIDTH-1]) begin
          add_phase_q <= 1'b1;
        end else begin
          add_phase_q <= 1'b0;
          b_q         <= {b_q[WIDTH-2:0], 1'b0};
          if (cnt_q == '0) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
      end
    end
  end

  assign result_o = r_q;
  assign done_o   = done_q;

endmodule

### rtl/miller_rabin_primality_test_unit.sv
// Top level of the deterministic Miller-Rabin primality test unit.
// Use: raise start with number_i while busy is low; that edge is the input
// transfer. busy rises on the next cycle and stays high until the answer has
// been given. The answer appears on prime_flag_o, marked by valid_o, which is
// high for exactly one cycle; the receiver cannot hold it off and must take
// it in that cycle. Only the low WIDTH bits of number_i are tested.
// Zero, one and even numbers are settled without the multiplier; otherwise
// the test runs up to thirteen bases, each a modular exponentiation and a
// squaring chain on one shared radix-2 modular multiplier; composites
// usually finish after the first base. One item at a time: the multiplier
// and the sequencer below set the rate.
// Reset clears the sequencer to idle with busy and valid_o low; any test in
// progress is dropped.
`include "miller_rabin_primality_test_unit_assert.svh"

module miller_rabin_primality_test_unit #(
  parameter int unsigned WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [63:0] number_i,
  output logic        busy,
  output logic        valid_o,
  output logic        prime_flag_o
);

  localparam int unsigned SW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIV, S_SPLIT, S_BASE, S_EXP, S_MACC, S_MSQ, S_WIT, S_WSQ, S_DONE
  } state_e;

  state_e                         state_q;
  logic [WIDTH-1:0]               n_q, d_q, e_q, acc_q, sq_q, x_q;
  logic [SW-1:0]                  s_q, k_q;
  logic [mrp_pkg::BaseIdxW-1:0]   idx_q;
  logic                           busy_q, valid_q, flag_q;
  mrp_pkg::mul_req_t              mul_req_q;
  logic [WIDTH-1:0]               mul_a_q, mul_b_q, mul_res;
  logic                           mul_done;
  logic [WIDTH-1:0]               base_w;

  assign base_w = {{(WIDTH-mrp_pkg::BaseW){1'b0}}, mrp_pkg::base_value(idx_q)};

  mrp_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mul_req_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .n_i     (n_q),
    .result_o(mul_res),
    .done_o  (mul_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      busy_q    <= 1'b0;
      valid_q   <= 1'b0;
      flag_q    <= 1'b0;
      mul_req_q <= '0;
      idx_q     <= '0;
      s_q       <= '0;
      k_q       <= '0;
    end else begin
      valid_q         <= 1'b0;
      mul_req_q.start <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            n_q     <= number_i[WIDTH-1:0];
            busy_q  <= 1'b1;
            state_q <= S_TRIV;
          end
        end
        S_TRIV: begin
          // Settle zero, one and even numbers without the multiplier.
          if (n_q[WIDTH-1:1] == '0) begin
            flag_q  <= 1'b0;
            state_q <= S_DONE;
          end else if (!n_q[0]) begin
            flag_q  <= (n_q == WIDTH'(2));
            state_q <= S_DONE;
          end else begin
            d_q     <= n_q - 1'b1;
            s_q     <= '0;
            state_q <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          // Strip one factor of two per cycle.
          if (!d_q[0]) begin
            d_q <= d_q >> 1;
            s_q <= s_q + 1'b1;
          end else begin
            idx_q   <= '0;
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          // A multiple of the base fails the witness chain, so no separate
          // divisibility check is needed.
          if (idx_q == mrp_pkg::BaseIdxW'(mrp_pkg::NumBases) || n_q == base_w) begin
            flag_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            acc_q   <= WIDTH'(1);
            sq_q    <= base_w;
            e_q     <= d_q;
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          if (e_q == '0) begin
            x_q     <= acc_q;
            k_q     <= '0;
            state_q <= S_WIT;
          end else if (e_q[0]) begin
            mul_a_q   <= acc_q;
            mul_b_q   <= sq_q;
            mul_req_q <= '{start: 1'b1, square: 1'b0};
            state_q   <= S_MACC;
          end else begin
            mul_b_q   <= sq_q;
            mul_req_q <= '{start: 1'b1, square: 1'b1};
            state_q   <= S_MSQ;
          end
        end
        S_MACC: begin
          if (mul_done) begin
            acc_q     <= mul_res;
            mul_b_q   <= sq_q;
            mul_req_q <= '{start: 1'b1, square: 1'b1};
            state_q   <= S_MSQ;
          end
        end
        S_MSQ: begin
          if (mul_done) begin
            sq_q    <= mul_res;
            e_q     <= e_q >> 1;
            state_q <= S_EXP;
          end
        end
        S_WIT: begin
          // Pass on x=1 at start or on n-1 before k=s; fail at k=s or x=1.
          if ((k_q == '0 && x_q == WIDTH'(1)) ||
              (k_q != s_q && x_q == n_q - 1'b1)) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_BASE;
          end else if (k_q == s_q || x_q == WIDTH'(1)) begin
            flag_q  <= 1'b0;
            state_q <= S_DONE;
          end else begin
            mul_b_q   <= x_q;
            mul_req_q <= '{start: 1'b1, square: 1'b1};
            state_q   <= S_WSQ;
          end
        end
        S_WSQ: begin
          if (mul_done) begin
            x_q     <= mul_res;
            k_q     <= k_q + 1'b1;
            state_q <= S_WIT;
          end
        end
        S_DONE: begin
          valid_q <= 1'b1;
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = busy_q;
  assign valid_o      = valid_q;
  assign prime_flag_o = flag_q;

  `MRP_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `MRP_ASSERT_IMP(a_valid_idle, valid_o, !busy && state_q == S_IDLE, "result while busy")
  `MRP_ASSERT_NXT(a_valid_pulse, valid_o, !valid_o, "result held longer than one cycle")
  `MRP_ASSERT_IMP(a_mul_wait, mul_done, state_q == S_MACC || state_q == S_MSQ ||
                  state_q == S_WSQ, "multiplier finished while nobody waited")

endmodule
